// ===== sv/bufu_pkg.sv =====
// shared types and constants for the buffered uart fifo pair
`timescale 1ns / 1ps

package bufu_pkg;

  localparam int COUNT_W = 6;
  localparam logic [7:0] NO_BYTE = 8'hff;

  typedef enum logic [1:0] {
    CMD_LINE_RX  = 2'd0,
    CMD_CPU_READ = 2'd1,
    CMD_CPU_SEND = 2'd2,
    CMD_TX_READY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'b00,
    SRC_RX   = 2'b01,
    SRC_TX   = 2'b10
  } src_t;

  typedef struct packed {
    src_t               src;
    logic               ok;
    logic [COUNT_W-1:0] rx_count;
    logic               irq;
  } res_t;

endpackage

// ===== sv/bufu_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module bufu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH_BITS = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [DEPTH_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [DEPTH_BITS-1:0] raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [(1 << DEPTH_BITS)];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bufu_ctrl.sv =====
// ring pointer control: full/empty decisions, memory requests, irq enable
`timescale 1ns / 1ps

module bufu_ctrl
  import bufu_pkg::*;
#(
  parameter int RX_DEPTH_BITS = 6,
  parameter int TX_DEPTH_BITS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  cmd_t                     cmd,
  output logic                     rx_we,
  output logic [RX_DEPTH_BITS-1:0] rx_waddr,
  output logic                     rx_re,
  output logic [RX_DEPTH_BITS-1:0] rx_raddr,
  output logic                     tx_we,
  output logic [TX_DEPTH_BITS-1:0] tx_waddr,
  output logic                     tx_re,
  output logic [TX_DEPTH_BITS-1:0] tx_raddr,
  output res_t                     res
);

  logic [RX_DEPTH_BITS-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt;
  logic [TX_DEPTH_BITS-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt;
  logic                     irq_r, irq_nxt;
  logic [RX_DEPTH_BITS-1:0] rx_wr_inc, rx_diff;
  logic [TX_DEPTH_BITS-1:0] tx_wr_inc;
  logic                     rx_full, rx_empty, tx_full, tx_empty;
  logic                     ok;
  src_t                     src;

  assign rx_wr_inc = rx_wr_r + 1'b1;
  assign tx_wr_inc = tx_wr_r + 1'b1;
  assign rx_full   = (rx_wr_inc == rx_rd_r);
  assign rx_empty  = (rx_wr_r == rx_rd_r);
  assign tx_full   = (tx_wr_inc == tx_rd_r);
  assign tx_empty  = (tx_wr_r == tx_rd_r);

  always_comb begin
    rx_wr_nxt = rx_wr_r;
    rx_rd_nxt = rx_rd_r;
    tx_wr_nxt = tx_wr_r;
    tx_rd_nxt = tx_rd_r;
    irq_nxt   = irq_r;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    ok        = 1'b0;
    src       = SRC_NONE;
    case (cmd)
      CMD_LINE_RX: begin
        if (!rx_full) begin
          rx_we     = fire;
          rx_wr_nxt = rx_wr_inc;
          ok        = 1'b1;
        end
      end
      CMD_CPU_READ: begin
        if (!rx_empty) begin
          rx_re     = fire;
          rx_rd_nxt = rx_rd_r + 1'b1;
          ok        = 1'b1;
          src       = SRC_RX;
        end
      end
      CMD_CPU_SEND: begin
        if (!tx_full) begin
          tx_we     = fire;
          tx_wr_nxt = tx_wr_inc;
          irq_nxt   = 1'b1;
          ok        = 1'b1;
        end
      end
      CMD_TX_READY: begin
        if (tx_empty) begin
          irq_nxt = 1'b0;
        end else begin
          tx_re     = fire;
          tx_rd_nxt = tx_rd_r + 1'b1;
          ok        = 1'b1;
          src       = SRC_TX;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign rx_diff  = rx_wr_nxt - rx_rd_nxt;
  assign rx_waddr = rx_wr_r;
  assign rx_raddr = rx_rd_r;
  assign tx_waddr = tx_wr_r;
  assign tx_raddr = tx_rd_r;

  always_comb begin
    res.src      = src;
    res.ok       = ok;
    res.rx_count = COUNT_W'(rx_diff);
    res.irq      = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_r <= '0;
      rx_rd_r <= '0;
      tx_wr_r <= '0;
      tx_rd_r <= '0;
      irq_r   <= 1'b0;
    end else if (fire) begin
      rx_wr_r <= rx_wr_nxt;
      rx_rd_r <= rx_rd_nxt;
      tx_wr_r <= tx_wr_nxt;
      tx_rd_r <= tx_rd_nxt;
      irq_r   <= irq_nxt;
    end
  end

endmodule

// ===== sv/buffered_uart_fifo_pair.sv =====
// top level: receive and transmit byte rings with command stream and result stream
`timescale 1ns / 1ps

// Each command beat yields one result beat. On the accept edge the ring
// memory is read into its registered read data; once the output register
// is free, that data is taken into the output register, and only then is
// a new command taken. The output register lets one command be accepted
// while the previous result still waits. Each ring holds 2^DEPTH_BITS - 1
// bytes; rx_count reports the receive fill in six bits.
module buffered_uart_fifo_pair
  import bufu_pkg::*;
#(
  parameter int RX_DEPTH_BITS = 6,
  parameter int TX_DEPTH_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_in
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // data_out, success, rx_count, tx_irq_enable
);

  logic                     fire;
  logic                     rx_we, rx_re, tx_we, tx_re;
  logic [RX_DEPTH_BITS-1:0] rx_waddr, rx_raddr;
  logic [TX_DEPTH_BITS-1:0] tx_waddr, tx_raddr;
  logic [7:0]               rx_rdata, tx_rdata;
  res_t                     res;
  res_t                     s1_res_r;
  logic                     s1_valid_r;
  logic                     out_valid_r;
  logic [15:0]              out_data_r;
  logic                     out_free;
  logic                     s1_move;
  logic [7:0]               s1_byte;

  assign in_tready = !s1_valid_r;
  assign fire      = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;

  bufu_ctrl #(
    .RX_DEPTH_BITS(RX_DEPTH_BITS),
    .TX_DEPTH_BITS(TX_DEPTH_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .cmd      (cmd_t'(in_tuser)),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_re    (rx_re),
    .rx_raddr (rx_raddr),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_re    (tx_re),
    .tx_raddr (tx_raddr),
    .res      (res)
  );

  bufu_ram #(
    .WIDTH(8),
    .DEPTH_BITS(RX_DEPTH_BITS)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (in_tdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  bufu_ram #(
    .WIDTH(8),
    .DEPTH_BITS(TX_DEPTH_BITS)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (in_tdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  always_comb begin
    case (s1_res_r.src)
      SRC_RX:  s1_byte = rx_rdata;
      SRC_TX:  s1_byte = tx_rdata;
      default: s1_byte = NO_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res_r <= res;
    end
    if (s1_move) begin
      out_data_r <= {s1_res_r.irq, s1_res_r.rx_count, s1_res_r.ok, s1_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
